[sv/vrsv_pkg.sv]
// ----------------------------------------------------------------------------
// vrsv_pkg: shared types and constants
// Operation codes, memory sizes and the memory-op word that the front part
// hands to the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vrsv_pkg;

  localparam int PATTERN_BYTES   = 8192;
  localparam int NAMETABLE_BYTES = 4096;
  localparam int PAT_AW          = $clog2(PATTERN_BYTES);
  localparam int NT_AW           = $clog2(NAMETABLE_BYTES);

  localparam logic [2:0] OP_READ     = 3'd0;
  localparam logic [2:0] OP_WRITE    = 3'd1;
  localparam logic [2:0] OP_VBL_SET  = 3'd2;
  localparam logic [2:0] OP_VBL_CLR  = 3'd3;
  localparam logic [2:0] OP_FRAME    = 3'd4;
  localparam logic [2:0] OP_LINE     = 3'd5;
  localparam logic [2:0] OP_NEXTLINE = 3'd6;

  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_SPR_PTR = 3'd3;
  localparam logic [2:0] REG_SPR_DAT = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  localparam logic [2:0] CFG_NT0     = 3'd0;
  localparam logic [2:0] CFG_NT1     = 3'd1;
  localparam logic [2:0] CFG_NT2     = 3'd2;
  localparam logic [2:0] CFG_NT3     = 3'd3;
  localparam logic [2:0] CFG_PROTECT = 3'd4;

  localparam logic [1:0] MOP_NONE  = 2'd0;
  localparam logic [1:0] MOP_READ  = 2'd1;
  localparam logic [1:0] MOP_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic              is_nt;
    logic [PAT_AW-1:0] addr;
    logic [7:0]        wdata;
    logic [7:0]        rd;
    logic              vblank;
    logic [15:0]       vaddr;
  } mem_op_t;

endpackage
`default_nettype wire

[sv/video_register_scroll_vram_port_unit.sv]
// ----------------------------------------------------------------------------
// video_register_scroll_vram_port_unit: CPU register port with video memory
// Register decode, loopy scroll addressing, palette, pattern and nametables.
// ----------------------------------------------------------------------------
// Input stream s_axis: one word per register read, write or timing event.
// Output stream m_axis: exactly one result word per input word, in order,
// carrying the read byte, the vblank flag and the current VRAM address.
// APB port: nametable page map (regs 0..3) and pattern write protect (reg 4);
// the user must write them only while the block is idle; the block does not enforce this.
// Throughput is one word per cycle while no clear or output stall holds it:
// decode and scroll state update, then a two-word queue, then one memory
// access per cycle on the single port of the pattern/nametable memory.
// Accepted words are written into the queue; results are registered at pop.
// After reset the block sweeps both memories to zero, one address a cycle,
// over every pattern address; s_axis_tready stays low during that sweep.
// When m_axis_tready is low the result is held, the queue fills, and then
// s_axis_tready drops until the receiver takes a word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module video_register_scroll_vram_port_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] opcode, [5:3] reg_index, [13:6] write_data
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [8] vblank_flag, [24:9] vram_address
  output logic [31:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0][1:0]   nt_page;
  logic              protect;
  logic              cfg_we;
  logic              accept, q_full, q_valid, pop, clearing;
  vrsv_pkg::mem_op_t f_op, q_op;
  logic [7:0]        out_rd;
  logic              out_vblank;
  logic [15:0]       out_vaddr;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      nt_page <= {2'd1, 2'd1, 2'd0, 2'd0};
      protect <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        vrsv_pkg::CFG_NT0:     nt_page[0] <= pwdata[1:0];
        vrsv_pkg::CFG_NT1:     nt_page[1] <= pwdata[1:0];
        vrsv_pkg::CFG_NT2:     nt_page[2] <= pwdata[1:0];
        vrsv_pkg::CFG_NT3:     nt_page[3] <= pwdata[1:0];
        vrsv_pkg::CFG_PROTECT: protect    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      vrsv_pkg::CFG_NT0:     prdata = {30'd0, nt_page[0]};
      vrsv_pkg::CFG_NT1:     prdata = {30'd0, nt_page[1]};
      vrsv_pkg::CFG_NT2:     prdata = {30'd0, nt_page[2]};
      vrsv_pkg::CFG_NT3:     prdata = {30'd0, nt_page[3]};
      vrsv_pkg::CFG_PROTECT: prdata = {31'd0, protect};
      default:               prdata = '0;
    endcase
  end

  assign s_axis_tready = !q_full && !clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;

  vrsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (s_axis_tdata[2:0]),
    .reg_index  (s_axis_tdata[5:3]),
    .write_data (s_axis_tdata[13:6]),
    .nt_page    (nt_page),
    .protect    (protect),
    .op         (f_op)
  );

  vrsv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (f_op),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .dout  (q_op)
  );

  vrsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_rd     (out_rd),
    .out_vblank (out_vblank),
    .out_vaddr  (out_vaddr)
  );

  assign m_axis_tdata = {7'd0, out_vaddr, out_vblank, out_rd};

endmodule
`default_nettype wire

[sv/vrsv_front.sv]
// ----------------------------------------------------------------------------
// vrsv_front: register decode and scroll state
// Applies each item to the register file, scroll addresses and palette, and
// emits one memory-op word per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrsv_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [2:0]       opcode,
  input  wire logic [2:0]       reg_index,
  input  wire logic [7:0]       write_data,
  input  wire logic [3:0][1:0]  nt_page,
  input  wire logic             protect,
  output vrsv_pkg::mem_op_t     op
);

  logic [7:0]  regs [8];
  logic [7:0]  regs_next [8];
  logic [15:0] v, v_next, t, t_next;
  logic [2:0]  fine_x, fine_x_next;
  logic        toggle, toggle_next;
  logic [5:0]  step, step_next;
  logic [7:0]  spr_ptr, spr_ptr_next;
  logic [5:0]  pal [32];
  logic [7:0]  spr_mem [256];
  logic        spr_we, pal_all, pal_one;
  logic        render;
  logic [13:0] a14, fold;
  logic        is_pal;
  logic [15:0] v_inc, nl;

  assign render = regs[1][3] | regs[1][4];
  assign a14    = v[13:0];
  assign is_pal = a14 >= 14'h3F00;
  assign fold   = (a14 >= 14'h3000) ? (a14 & 14'h2FFF) : a14;
  assign v_inc  = v + {10'd0, step};

  always_comb begin
    nl = v;
    if (v[14:12] == 3'b111) begin
      nl = v & 16'h8FFF;
      if ((nl & 16'h03E0) == 16'h03A0) begin
        nl = (nl ^ 16'h0800) & 16'hFC1F;
      end else if ((nl & 16'h03E0) == 16'h03E0) begin
        nl = nl & 16'hFC1F;
      end else begin
        nl = nl + 16'h0020;
      end
    end else begin
      nl = v + 16'h1000;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) regs_next[i] = regs[i];
    v_next       = v;
    t_next       = t;
    fine_x_next  = fine_x;
    toggle_next  = toggle;
    step_next    = step;
    spr_ptr_next = spr_ptr;
    spr_we       = 1'b0;
    pal_all      = 1'b0;
    pal_one      = 1'b0;
    op           = '0;
    op.kind      = vrsv_pkg::MOP_NONE;
    op.is_nt     = fold[13];
    op.addr      = fold[13] ? vrsv_pkg::PAT_AW'({nt_page[fold[11:10]], fold[9:0]})
                            : fold[vrsv_pkg::PAT_AW-1:0];
    op.wdata     = write_data;
    case (opcode)
      vrsv_pkg::OP_READ: begin
        if (reg_index == vrsv_pkg::REG_STATUS) begin
          op.rd        = regs[2];
          regs_next[2] = regs[2] & 8'h7F;
          toggle_next  = 1'b0;
        end else if (reg_index == vrsv_pkg::REG_DATA) begin
          v_next = v_inc;
          if (is_pal) begin
            op.rd = {2'b00, pal[a14[4:0]]};
          end else begin
            op.kind = vrsv_pkg::MOP_READ;
          end
        end else begin
          op.rd = regs[reg_index];
        end
      end
      vrsv_pkg::OP_WRITE: begin
        regs_next[reg_index] = write_data;
        case (reg_index)
          vrsv_pkg::REG_CTRL: begin
            step_next = write_data[2] ? 6'd32 : 6'd1;
            t_next    = (t & 16'hF3FF) | {4'd0, write_data[1:0], 10'd0};
          end
          vrsv_pkg::REG_SPR_PTR: spr_ptr_next = write_data;
          vrsv_pkg::REG_SPR_DAT: begin
            spr_we       = 1'b1;
            spr_ptr_next = spr_ptr + 8'd1;
          end
          vrsv_pkg::REG_SCROLL: begin
            toggle_next = ~toggle;
            if (!toggle) begin
              t_next      = (t & 16'hFFE0) | {11'd0, write_data[7:3]};
              fine_x_next = write_data[2:0];
            end else begin
              t_next = (t & 16'h8C1F) | {1'b0, write_data[2:0], 2'd0, write_data[7:3], 5'd0};
            end
          end
          vrsv_pkg::REG_ADDR: begin
            toggle_next = ~toggle;
            if (!toggle) begin
              t_next = (t & 16'h00FF) | {2'd0, write_data[5:0], 8'd0};
            end else begin
              t_next = {t[15:8], write_data};
              v_next = {t[15:8], write_data};
            end
          end
          vrsv_pkg::REG_DATA: begin
            v_next = v_inc;
            if (is_pal) begin
              pal_all = a14[3:0] == 4'd0;
              pal_one = a14[1:0] != 2'd0;
            end else if (!(protect && !fold[13])) begin
              op.kind = vrsv_pkg::MOP_WRITE;
            end
          end
          default: ;
        endcase
      end
      vrsv_pkg::OP_VBL_SET: regs_next[2] = regs[2] | 8'h80;
      vrsv_pkg::OP_VBL_CLR: regs_next[2] = regs[2] & 8'h3F;
      vrsv_pkg::OP_FRAME:    if (render) v_next = t;
      vrsv_pkg::OP_LINE:     if (render) v_next = (v & 16'hFBE0) | (t & 16'h041F);
      vrsv_pkg::OP_NEXTLINE: if (render) v_next = nl;
      default: ;
    endcase
    op.vblank = regs_next[2][7];
    op.vaddr  = v_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) regs[i] <= '0;
      for (int i = 0; i < 32; i++) pal[i] <= '0;
      v       <= '0;
      t       <= '0;
      fine_x  <= '0;
      toggle  <= 1'b0;
      step    <= '0;
      spr_ptr <= '0;
    end else if (accept) begin
      for (int i = 0; i < 8; i++) regs[i] <= regs_next[i];
      v       <= v_next;
      t       <= t_next;
      fine_x  <= fine_x_next;
      toggle  <= toggle_next;
      step    <= step_next;
      spr_ptr <= spr_ptr_next;
      // colour 0 fans out to every mirror
      if (pal_all) begin
        for (int i = 0; i < 32; i += 4) pal[i] <= write_data[5:0];
      end else if (pal_one) begin
        pal[a14[4:0]] <= write_data[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && spr_we) begin
      spr_mem[spr_ptr] <= write_data;
    end
  end

endmodule
`default_nettype wire

[sv/vrsv_queue.sv]
// ----------------------------------------------------------------------------
// vrsv_queue: two-word queue
// Decouples the decode side from the memory side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrsv_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  vrsv_pkg::mem_op_t  din,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output vrsv_pkg::mem_op_t  dout
);

  vrsv_pkg::mem_op_t ent [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign dout  = ent[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wptr] <= din;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !valid))
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1 && pop && !push) |=> !valid)
    else $error("queue not empty after last pop");
`endif

endmodule
`default_nettype wire

[sv/vrsv_back.sv]
// ----------------------------------------------------------------------------
// vrsv_back: video memory and result register
// Holds pattern and nametable memory, the read buffer and the output stage;
// clears both memories after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrsv_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  vrsv_pkg::mem_op_t  q_op,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_rd,
  output logic               out_vblank,
  output logic [15:0]        out_vaddr
);

  logic [7:0] pat [vrsv_pkg::PATTERN_BYTES];
  logic [7:0] nt  [vrsv_pkg::NAMETABLE_BYTES];
  logic [7:0] read_buffer;
  logic [vrsv_pkg::PAT_AW:0] clr_cnt;

  assign clearing = !clr_cnt[vrsv_pkg::PAT_AW];
  assign pop      = q_valid && !clearing && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (clearing) begin
      pat[clr_cnt[vrsv_pkg::PAT_AW-1:0]] <= '0;
      nt[clr_cnt[vrsv_pkg::NT_AW-1:0]]   <= '0;
    end else if (pop && q_op.kind == vrsv_pkg::MOP_WRITE) begin
      if (q_op.is_nt) begin
        nt[q_op.addr[vrsv_pkg::NT_AW-1:0]] <= q_op.wdata;
      end else begin
        pat[q_op.addr] <= q_op.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
      read_buffer <= '0;
    end else begin
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // buffered read: hand out the old byte, load the new one
      if (pop && q_op.kind == vrsv_pkg::MOP_READ) begin
        read_buffer <= q_op.is_nt ? nt[q_op.addr[vrsv_pkg::NT_AW-1:0]] : pat[q_op.addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rd     <= (q_op.kind == vrsv_pkg::MOP_READ) ? read_buffer : q_op.rd;
      out_vblank <= q_op.vblank;
      out_vaddr  <= q_op.vaddr;
    end
  end

endmodule
`default_nettype wire

[sim/video_register_scroll_vram_port_unit_tb.sv]
// ----------------------------------------------------------------------------
// video_register_scroll_vram_port_unit_tb: self-checking bench for the port
// Drives register reads, writes and timing events on the input stream,
// predicts every result word with a behavioral copy of the scroll, palette
// and video memory logic, and compares each output word field by field.
// Both streams idle at random; APB page maps change between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module video_register_scroll_vram_port_unit_tb;

  localparam logic [2:0] OP_NONE  = 3'd7;
  localparam logic [2:0] REG_MASK = 3'd1;
  localparam int IDLE_LIMIT = 30000;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic [7:0]  rd;
    logic        vbl;
    logic [15:0] vaddr;
  } result_t;

  typedef struct {
    logic [2:0] op;
    logic [2:0] r;
    logic [7:0] d;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  video_register_scroll_vram_port_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // model state
  logic [7:0]  regs_b [8];
  logic [15:0] cur_v, tmp_t;
  logic [2:0]  fine_x;
  logic        wtog;
  logic [5:0]  addr_step;
  logic [7:0]  rbuf, spr_ptr;
  logic [7:0]  spr_mem [256];
  logic [5:0]  pal_mem [32];
  logic [7:0]  pat_mem [vrsv_pkg::PATTERN_BYTES];
  logic [7:0]  nt_mem [vrsv_pkg::NAMETABLE_BYTES];
  logic [1:0]  nt_map [4];
  logic        pat_protect;

  result_t result_q [$];
  int errors = 0;
  int words_in = 0, words_out = 0, idle_cycles = 0;
  int reads_seen = 0, events_seen = 0;
  bit hold_req = 1'b0;

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0h want %0h (word %0d)", what, got, want, words_out);
    errors++;
  endtask

  function automatic int nt_index(logic [15:0] a);
    return ({nt_map[a[11:10]], 10'b0} | (a & 16'h03FF)) & (vrsv_pkg::NAMETABLE_BYTES - 1);
  endfunction

  function automatic logic [7:0] vram_read();
    logic [15:0] a;
    logic [7:0] old;
    a = cur_v & 16'h3FFF;
    cur_v = cur_v + 16'(addr_step);
    if (a >= 16'h3F00) return 8'(pal_mem[a[4:0]]);
    if (a >= 16'h3000) a &= 16'hEFFF;
    old = rbuf;
    rbuf = (a < 16'h2000) ? pat_mem[a[12:0]] : nt_mem[nt_index(a)];
    return old;
  endfunction

  function automatic void vram_write(logic [7:0] d);
    logic [15:0] a;
    a = cur_v & 16'h3FFF;
    cur_v = cur_v + 16'(addr_step);
    if (a >= 16'h3F00) begin
      // colour 0 fans out to every mirror; other multiples of four drop
      if (a[3:0] == 4'd0) begin
        for (int i = 0; i < 32; i += 4) pal_mem[i] = d[5:0];
      end else if (a[1:0] != 2'd0) begin
        pal_mem[a[4:0]] = d[5:0];
      end
      return;
    end
    if (a >= 16'h3000) a &= 16'hEFFF;
    if (a < 16'h2000) begin
      if (!pat_protect) pat_mem[a[12:0]] = d;
    end else begin
      nt_mem[nt_index(a)] = d;
    end
  endfunction

  function automatic result_t predict_word(logic [2:0] op, logic [2:0] r, logic [7:0] d);
    result_t res;
    logic render;
    logic [15:0] v;
    res.rd = 8'd0;
    render = (regs_b[REG_MASK] & 8'h18) != 0;
    case (op)
      vrsv_pkg::OP_READ: begin
        if (r == vrsv_pkg::REG_STATUS) begin
          res.rd = regs_b[vrsv_pkg::REG_STATUS];
          wtog = 1'b0;
          regs_b[vrsv_pkg::REG_STATUS][7] = 1'b0;
        end else if (r == vrsv_pkg::REG_DATA) begin
          res.rd = vram_read();
        end else begin
          res.rd = regs_b[r];
        end
      end
      vrsv_pkg::OP_WRITE: begin
        regs_b[r] = d;
        case (r)
          vrsv_pkg::REG_CTRL: begin
            addr_step = d[2] ? 6'd32 : 6'd1;
            tmp_t[11:10] = d[1:0];
          end
          vrsv_pkg::REG_SPR_PTR: spr_ptr = d;
          vrsv_pkg::REG_SPR_DAT: begin
            spr_mem[spr_ptr] = d;
            spr_ptr++;
          end
          vrsv_pkg::REG_SCROLL: begin
            wtog = ~wtog;
            if (wtog) begin
              tmp_t[4:0] = d[7:3];
              fine_x = d[2:0];
            end else begin
              tmp_t[9:5] = d[7:3];
              tmp_t[14:12] = d[2:0];
            end
          end
          vrsv_pkg::REG_ADDR: begin
            wtog = ~wtog;
            if (wtog) begin
              tmp_t[15:8] = {2'b00, d[5:0]};
            end else begin
              tmp_t[7:0] = d;
              cur_v = tmp_t;
            end
          end
          vrsv_pkg::REG_DATA: vram_write(d);
          default: ;
        endcase
      end
      vrsv_pkg::OP_VBL_SET: regs_b[vrsv_pkg::REG_STATUS][7] = 1'b1;
      vrsv_pkg::OP_VBL_CLR: regs_b[vrsv_pkg::REG_STATUS] &= 8'h3F;
      vrsv_pkg::OP_FRAME: if (render) cur_v = tmp_t;
      vrsv_pkg::OP_LINE: if (render) cur_v = (cur_v & 16'hFBE0) | (tmp_t & 16'h041F);
      vrsv_pkg::OP_NEXTLINE: if (render) begin
        v = cur_v;
        if ((v & 16'h7000) == 16'h7000) begin
          v &= 16'h8FFF;
          if ((v & 16'h03E0) == 16'h03A0) v = (v ^ 16'h0800) & 16'hFC1F;
          else if ((v & 16'h03E0) == 16'h03E0) v &= 16'hFC1F;
          else v = v + 16'h0020;
        end else begin
          v = v + 16'h1000;
        end
        cur_v = v;
      end
      default: ;
    endcase
    res.vbl = regs_b[vrsv_pkg::REG_STATUS][7];
    res.vaddr = cur_v;
    return res;
  endfunction

  task automatic send_word(logic [2:0] op, logic [2:0] r, logic [7:0] d,
                           bit typed = 0, result_t want = '0);
    int gap;
    result_t res;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, d, r, op};
    do @(posedge clk); while (!s_axis_tready);
    res = predict_word(op, r, d);
    result_q.push_back(typed ? want : res);
    words_in++;
    if (op == vrsv_pkg::OP_READ) reads_seen++;
    if (op >= vrsv_pkg::OP_VBL_SET) events_seen++;
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    if (idx == vrsv_pkg::CFG_PROTECT) pat_protect = val[0];
    else nt_map[idx[1:0]] = val[1:0];
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_addr_hi();
    case ($urandom_range(0, 4))
      0: return 8'h3F;
      1: return 8'(8'h30 | $urandom_range(0, 15));
      2: return 8'(8'h20 | $urandom_range(0, 15));
      3: return 8'($urandom_range(0, 31));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_burst();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // point the data port somewhere, then stream through it
        send_word(vrsv_pkg::OP_READ, vrsv_pkg::REG_STATUS, 8'($urandom));
        send_word(vrsv_pkg::OP_WRITE, vrsv_pkg::REG_ADDR, pick_addr_hi());
        send_word(vrsv_pkg::OP_WRITE, vrsv_pkg::REG_ADDR, 8'($urandom));
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 1))
            send_word(vrsv_pkg::OP_WRITE, vrsv_pkg::REG_DATA, 8'($urandom));
          else
            send_word(vrsv_pkg::OP_READ, vrsv_pkg::REG_DATA, 8'($urandom));
        end
      end
      4: begin
        send_word(vrsv_pkg::OP_WRITE, vrsv_pkg::REG_CTRL, 8'($urandom));
        send_word(vrsv_pkg::OP_WRITE, REG_MASK,
                  ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom));
      end
      5: begin
        send_word(vrsv_pkg::OP_WRITE, vrsv_pkg::REG_SCROLL, 8'($urandom));
        send_word(vrsv_pkg::OP_WRITE, vrsv_pkg::REG_SCROLL, 8'($urandom));
      end
      6: begin
        send_word(vrsv_pkg::OP_VBL_SET, 3'($urandom), 8'($urandom));
        send_word(vrsv_pkg::OP_FRAME, 3'($urandom), 8'($urandom));
        n = $urandom_range(1, 10);
        repeat (n) begin
          send_word(vrsv_pkg::OP_LINE, 3'($urandom), 8'($urandom));
          send_word(vrsv_pkg::OP_NEXTLINE, 3'($urandom), 8'($urandom));
        end
        send_word(vrsv_pkg::OP_VBL_CLR, 3'($urandom), 8'($urandom));
      end
      7: begin
        send_word(vrsv_pkg::OP_WRITE, vrsv_pkg::REG_SPR_PTR, 8'($urandom));
        send_word(vrsv_pkg::OP_WRITE, vrsv_pkg::REG_SPR_DAT, 8'($urandom));
        send_word(vrsv_pkg::OP_READ, vrsv_pkg::REG_SPR_DAT, 8'($urandom));
      end
      8: send_word(3'($urandom), 3'($urandom), 8'($urandom));
      default: send_word(vrsv_pkg::OP_READ, 3'($urandom), 8'($urandom));
    endcase
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin : sink_ready
    int wait_left;
    int hold_left;
    if (rst) begin
      m_axis_tready <= 1'b0;
      wait_left = 0;
      hold_left = 0;
    end else if (hold_req || hold_left > 0) begin
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      wait_left = 0;
      hold_left--;
      m_axis_tready <= (hold_left == 0);
    end else if (wait_left > 0) begin
      wait_left--;
      m_axis_tready <= (wait_left == 0);
    end else if ($urandom_range(0, 9) < 7) begin
      m_axis_tready <= 1'b1;
    end else begin
      wait_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      m_axis_tready <= 1'b0;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) idle_cycles = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        if (result_q.size() == 0) begin
          $display("UNEXPECTED word %0h", m_axis_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[7:0] != want.rd) report("read_data", m_axis_tdata[7:0], want.rd);
          if (m_axis_tdata[8] != want.vbl) report("vblank_flag", m_axis_tdata[8], want.vbl);
          if (m_axis_tdata[24:9] != want.vaddr)
            report("vram_address", m_axis_tdata[24:9], want.vaddr);
        end
        words_out++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout with %0d words outstanding", result_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  stim_row_t rows [$];

  initial begin
    logic [1:0] pages [4];
    int target;
    for (int i = 0; i < 8; i++) regs_b[i] = 8'd0;
    cur_v = '0; tmp_t = '0; fine_x = '0; wtog = 1'b0; addr_step = '0;
    rbuf = '0; spr_ptr = '0;
    foreach (spr_mem[i]) spr_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    foreach (pat_mem[i]) pat_mem[i] = '0;
    foreach (nt_mem[i]) nt_mem[i] = '0;
    nt_map[0] = 2'd0; nt_map[1] = 2'd0; nt_map[2] = 2'd1; nt_map[3] = 2'd1;
    pat_protect = 1'b0;

    rows = '{
      '{vrsv_pkg::OP_READ, vrsv_pkg::REG_STATUS, 8'h00, 1, '{8'h00, 1'b0, 16'h0000}},
      '{vrsv_pkg::OP_VBL_SET, 3'd0, 8'h00, 1, '{8'h00, 1'b1, 16'h0000}},
      '{vrsv_pkg::OP_READ, vrsv_pkg::REG_STATUS, 8'h00, 1, '{8'h80, 1'b0, 16'h0000}},
      '{OP_NONE, 3'd7, 8'hFF, 1, '{8'h00, 1'b0, 16'h0000}},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_CTRL, 8'h04, 0, '0},
      '{vrsv_pkg::OP_WRITE, REG_MASK, 8'h18, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_SCROLL, 8'hFF, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_SCROLL, 8'hFF, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_ADDR, 8'h3F, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_ADDR, 8'h00, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_DATA, 8'hFF, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_DATA, 8'h15, 0, '0},
      '{vrsv_pkg::OP_READ, vrsv_pkg::REG_DATA, 8'h00, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_ADDR, 8'h30, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_ADDR, 8'h00, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_DATA, 8'hA5, 0, '0},
      '{vrsv_pkg::OP_READ, vrsv_pkg::REG_DATA, 8'h00, 0, '0},
      '{vrsv_pkg::OP_READ, vrsv_pkg::REG_DATA, 8'h00, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_SPR_PTR, 8'hFF, 0, '0},
      '{vrsv_pkg::OP_WRITE, vrsv_pkg::REG_SPR_DAT, 8'h5A, 0, '0},
      '{vrsv_pkg::OP_FRAME, 3'd0, 8'h00, 0, '0},
      '{vrsv_pkg::OP_LINE, 3'd0, 8'h00, 0, '0},
      '{vrsv_pkg::OP_NEXTLINE, 3'd0, 8'h00, 0, '0},
      '{vrsv_pkg::OP_VBL_CLR, 3'd0, 8'h00, 0, '0},
      '{vrsv_pkg::OP_READ, vrsv_pkg::REG_CTRL, 8'h00, 0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_word(rows[i].op, rows[i].r, rows[i].d, rows[i].typed, rows[i].want);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          pages = '{2'd3, 2'd3, 2'd3, 2'd3};
          apb_write(vrsv_pkg::CFG_PROTECT, 32'd1);
        end
        1: begin
          pages = '{2'd0, 2'd0, 2'd0, 2'd0};
          apb_write(vrsv_pkg::CFG_PROTECT, 32'd0);
        end
        2: begin
          pages = '{2'd0, 2'd1, 2'd2, 2'd3};
          apb_write(vrsv_pkg::CFG_PROTECT, 32'd1);
        end
        default: begin
          foreach (pages[k]) pages[k] = 2'($urandom);
          apb_write(vrsv_pkg::CFG_PROTECT, 32'($urandom_range(0, 1)));
        end
      endcase
      for (int k = 0; k < 4; k++) apb_write(3'(k), 32'(pages[k]));
      if (ph == 1) hold_req = 1'b1;
      target = words_in + PHASE_ITEMS;
      while (words_in < target) random_burst();
      wait_drained();
    end

    $display("Covered %0d words (%0d reads, %0d timing events) over six page maps",
             words_in, reads_seen, events_seen);
    $display("Checked %0d result words, %0d mismatches", words_out, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
sv/vrsv_pkg.sv
sv/vrsv_front.sv
sv/vrsv_queue.sv
sv/vrsv_back.sv
sv/video_register_scroll_vram_port_unit.sv
sim/video_register_scroll_vram_port_unit_tb.sv
